FILE: sv/gradient_non_max_suppression_core_macros.svh
// Assertion macros shared by the non-maximum suppression RTL.
// Expects clk and rst in the scope of the including module.
`ifndef GRADIENT_NON_MAX_SUPPRESSION_CORE_MACROS_SVH
`define GRADIENT_NON_MAX_SUPPRESSION_CORE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define GNMS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define GNMS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/gnms_pkg.sv
// Shared constants, types and helpers for the non-maximum suppression block.
// No dependencies.
package gnms_pkg;

  localparam int MAX_WIDTH = 4096;
  localparam int MAG_BITS  = 15;
  localparam int GRAD_W    = 16;
  localparam int ROW_W     = 16;
  localparam int COL_W     = $clog2(MAX_WIDTH);
  localparam int WIDTH_W   = 13;
  localparam int HEIGHT_W  = 16;
  localparam int DIFF_W    = MAG_BITS + 1;
  localparam int PROD_W    = DIFF_W + GRAD_W;
  localparam int PROJ_W    = PROD_W + 1;
  localparam int MIN_DIM   = 3;

  localparam logic [WIDTH_W-1:0]  RESET_WIDTH  = WIDTH_W'(2704);
  localparam logic [HEIGHT_W-1:0] RESET_HEIGHT = HEIGHT_W'(1520);

  // result codes
  localparam logic [1:0] CODE_BORDER    = 2'd0;
  localparam logic [1:0] CODE_NOT_MAX   = 2'd1;
  localparam logic [1:0] CODE_CANDIDATE = 2'd2;

  // configuration register indexes
  localparam logic CFG_IMAGE_WIDTH  = 1'b0;
  localparam logic CFG_IMAGE_HEIGHT = 1'b1;

  typedef logic [MAG_BITS-1:0]       mag_t;
  typedef logic [GRAD_W-1:0]         graw_t;
  typedef logic signed [GRAD_W-1:0]  gval_t;
  typedef logic signed [DIFF_W-1:0]  sval_t;
  typedef logic signed [PROD_W-1:0]  prod_t;
  typedef logic signed [PROJ_W-1:0]  proj_t;
  typedef logic [ROW_W-1:0]          row_t;
  typedef logic [COL_W-1:0]          col_t;

  // one line store entry: gradient of the row above and two magnitudes
  typedef struct packed {
    graw_t gy;
    graw_t gx;
    mag_t  prev;
    mag_t  prev2;
  } line_entry_t;

  // interpolation weights for both neighbors plus the centre gradient
  typedef struct packed {
    sval_t a1;
    sval_t b1;
    sval_t a2;
    sval_t b2;
    gval_t gx;
    gval_t gy;
  } oct_t;

  typedef struct packed {
    oct_t oct;
    logic zero;
    logic border;
    row_t row;
    col_t col;
    logic last;
  } dec_in_t;

  function automatic sval_t mdiff(mag_t x, mag_t y);
    return sval_t'({1'b0, x}) - sval_t'({1'b0, y});
  endfunction

endpackage

FILE: sv/gnms_line_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module gnms_line_ram #(
  parameter int DATA_W = 62,
  parameter int ADDR_W = 12
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [2**ADDR_W];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: sv/gnms_window.sv
// 3x3 magnitude window, centre gradient register and octant selection.
// Depends on gnms_pkg.
module gnms_window import gnms_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  shift_en,
  input  mag_t  col_top,
  input  mag_t  col_mid,
  input  mag_t  col_bot,
  input  logic [2*GRAD_W-1:0] new_grad,
  output oct_t  oct,
  output logic  centre_zero
);

  mag_t  win [3][3];
  mag_t  nw  [3][3];
  logic [2*GRAD_W-1:0] cg;
  gval_t gx;
  gval_t gy;
  logic signed [GRAD_W:0] gsum;
  mag_t  m;

  // window as it stands after this shift
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      nw[i][0] = win[i][1];
      nw[i][1] = win[i][2];
    end
    nw[0][2] = col_top;
    nw[1][2] = col_mid;
    nw[2][2] = col_bot;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          win[i][j] <= '0;
        end
      end
      cg <= '0;
    end else if (shift_en) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          win[i][j] <= nw[i][j];
        end
      end
      cg <= new_grad;
    end
  end

  assign gx   = gval_t'(cg[GRAD_W-1:0]);
  assign gy   = gval_t'(cg[2*GRAD_W-1:GRAD_W]);
  assign gsum = {gx[GRAD_W-1], gx} + {gy[GRAD_W-1], gy};
  assign m    = nw[1][1];
  assign centre_zero = (m == '0);

  always_comb begin
    oct.gx = gx;
    oct.gy = gy;
    if (!gx[GRAD_W-1]) begin
      if (!gy[GRAD_W-1]) begin
        if (gx >= gy) begin
          oct.a1 = mdiff(m, nw[1][0]);       oct.b1 = mdiff(nw[0][0], nw[1][0]);
          oct.a2 = mdiff(m, nw[1][2]);       oct.b2 = mdiff(nw[2][2], nw[1][2]);
        end else begin
          oct.a1 = mdiff(nw[0][1], nw[0][0]); oct.b1 = mdiff(nw[0][1], m);
          oct.a2 = mdiff(nw[2][1], nw[2][2]); oct.b2 = mdiff(nw[2][1], m);
        end
      end else begin
        if (!gsum[GRAD_W]) begin
          oct.a1 = mdiff(m, nw[1][0]);       oct.b1 = mdiff(nw[1][0], nw[2][0]);
          oct.a2 = mdiff(m, nw[1][2]);       oct.b2 = mdiff(nw[1][2], nw[0][2]);
        end else begin
          oct.a1 = mdiff(nw[2][1], nw[2][0]); oct.b1 = mdiff(m, nw[2][1]);
          oct.a2 = mdiff(nw[0][1], nw[0][2]); oct.b2 = mdiff(m, nw[0][1]);
        end
      end
    end else begin
      if (!gy[GRAD_W-1]) begin
        // -gx >= gy
        if (gsum[GRAD_W] || gsum == '0) begin
          oct.a1 = mdiff(nw[1][2], m);       oct.b1 = mdiff(nw[0][2], nw[1][2]);
          oct.a2 = mdiff(nw[1][0], m);       oct.b2 = mdiff(nw[2][0], nw[1][0]);
        end else begin
          oct.a1 = mdiff(nw[0][2], nw[0][1]); oct.b1 = mdiff(nw[0][1], m);
          oct.a2 = mdiff(nw[2][0], nw[2][1]); oct.b2 = mdiff(nw[2][1], m);
        end
      end else begin
        // third quadrant: ties go to the y-dominant case
        if (gx < gy) begin
          oct.a1 = mdiff(nw[1][2], m);       oct.b1 = mdiff(nw[1][2], nw[2][2]);
          oct.a2 = mdiff(nw[1][0], m);       oct.b2 = mdiff(nw[1][0], nw[0][0]);
        end else begin
          oct.a1 = mdiff(nw[2][2], nw[2][1]); oct.b1 = mdiff(m, nw[2][1]);
          oct.a2 = mdiff(nw[0][0], nw[0][1]); oct.b2 = mdiff(m, nw[0][1]);
        end
      end
    end
  end

endmodule

FILE: sv/gnms_decide.sv
// Projection multiply stage and decision/output register stage.
// Depends on gnms_pkg.
module gnms_decide import gnms_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  dec_in_t    in_data,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] code,
  output row_t       row,
  output col_t       col,
  output logic       last
);

  // product stage
  logic  c_valid;
  prod_t pa1, pb1, pa2, pb2;
  logic  c_zero, c_border, c_last;
  row_t  c_row;
  col_t  c_col;

  logic  o_free;
  logic  c_go;
  proj_t p1, p2;
  logic [1:0] code_next;

  assign o_free   = !out_valid || out_ready;
  assign c_go     = c_valid && o_free;
  assign in_ready = !c_valid || o_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
    end else if (in_ready) begin
      c_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      pa1      <= prod_t'(in_data.oct.a1) * prod_t'(in_data.oct.gx);
      pb1      <= prod_t'(in_data.oct.b1) * prod_t'(in_data.oct.gy);
      pa2      <= prod_t'(in_data.oct.a2) * prod_t'(in_data.oct.gx);
      pb2      <= prod_t'(in_data.oct.b2) * prod_t'(in_data.oct.gy);
      c_zero   <= in_data.zero;
      c_border <= in_data.border;
      c_row    <= in_data.row;
      c_col    <= in_data.col;
      c_last   <= in_data.last;
    end
  end

  // projections scaled by the positive magnitude
  assign p1 = proj_t'(pb1) - proj_t'(pa1);
  assign p2 = proj_t'(pb2) - proj_t'(pa2);

  always_comb begin
    if (c_border) begin
      code_next = CODE_BORDER;
    end else if (c_zero) begin
      code_next = CODE_NOT_MAX;
    end else if (p1 > proj_t'(0) || !p2[PROJ_W-1]) begin
      code_next = CODE_NOT_MAX;
    end else begin
      code_next = CODE_CANDIDATE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (o_free) begin
      out_valid <= c_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (c_go) begin
      code <= code_next;
      row  <= c_row;
      col  <= c_col;
      last <= c_last;
    end
  end

endmodule

FILE: sv/gradient_non_max_suppression_core.sv
// A result passes through the stage A, stage B, product and output registers to m_axis.
// Throughput: one pixel per cycle unless m_axis stalls, set by the single line RAM (1R/1W).
// Each stage has its own valid, so input keeps flowing into empty stages while a result waits.
// Reset: counters, window and valid bits clear; width/height return to 2704/1520.
// The line RAM is not cleared; no clearing pass, entries are written before use.
// Depends on gnms_pkg, gnms_line_ram, gnms_window, gnms_decide and the macro header.
`include "gradient_non_max_suppression_core_macros.svh"

module gradient_non_max_suppression_core import gnms_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  // configuration write port
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data,
  // pixel stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // grad_magnitude[14:0], grad_x[30:15], grad_y[46:31]
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // nms_code[1:0], centre_row[17:2], centre_col[29:18]
  output logic        m_axis_tlast    // frame_done
);

  // ---------------------------------------------------------------------------
  // Configuration. Any write restarts the frame.
  // ---------------------------------------------------------------------------
  logic [WIDTH_W-1:0]  image_width;
  logic [HEIGHT_W-1:0] image_height;
  logic [WIDTH_W-1:0]  eff_w;
  logic [HEIGHT_W-1:0] eff_h;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= RESET_WIDTH;
      image_height <= RESET_HEIGHT;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_IMAGE_WIDTH:  image_width  <= cfg_data[WIDTH_W-1:0];
        CFG_IMAGE_HEIGHT: image_height <= cfg_data[HEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  // saturate to the supported range
  always_comb begin
    if (image_width < WIDTH_W'(MIN_DIM)) begin
      eff_w = WIDTH_W'(MIN_DIM);
    end else if (image_width > WIDTH_W'(MAX_WIDTH)) begin
      eff_w = WIDTH_W'(MAX_WIDTH);
    end else begin
      eff_w = image_width;
    end
    eff_h = (image_height < HEIGHT_W'(MIN_DIM)) ? HEIGHT_W'(MIN_DIM) : image_height;
  end

  // ---------------------------------------------------------------------------
  // Raster position of the incoming pixel.
  // ---------------------------------------------------------------------------
  row_t row_cnt;
  col_t col_cnt;
  logic col_last, row_last;
  logic in_acc;

  assign col_last = ({1'b0, col_cnt} + WIDTH_W'(1)) >= eff_w;
  assign row_last = ({1'b0, row_cnt} + (ROW_W + 1)'(1)) >= {1'b0, eff_h};
  assign in_acc   = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk) begin
    if (rst || cfg_we) begin
      row_cnt <= '0;
      col_cnt <= '0;
    end else if (in_acc) begin
      if (col_last) begin
        col_cnt <= '0;
        row_cnt <= row_last ? '0 : row_cnt + ROW_W'(1);
      end else begin
        col_cnt <= col_cnt + COL_W'(1);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage A: pixel captured, line RAM read issued at the same edge.
  // ---------------------------------------------------------------------------
  logic  a_valid, a_free, a_go;
  mag_t  a_mag;
  graw_t a_gx, a_gy;
  col_t  a_col;
  row_t  a_crow;
  col_t  a_ccol;
  logic  a_emit, a_border, a_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (a_free) begin
      a_valid <= s_axis_tvalid;
    end
  end

  // result describes the pixel one row up and one column left
  always_ff @(posedge clk) begin
    if (in_acc) begin
      a_mag    <= s_axis_tdata[MAG_BITS-1:0];
      a_gx     <= s_axis_tdata[30:15];
      a_gy     <= s_axis_tdata[46:31];
      a_col    <= col_cnt;
      a_crow   <= row_cnt - ROW_W'(1);
      a_ccol   <= col_cnt - COL_W'(1);
      a_emit   <= (row_cnt != '0) && (col_cnt != '0);
      a_border <= (row_cnt == ROW_W'(1)) || (col_cnt == COL_W'(1));
      a_last   <= row_last && col_last;
    end
  end

  // ---------------------------------------------------------------------------
  // Line RAM: read at accept, write-back when the pixel leaves stage A.
  // Consecutive pixels always hit different columns (width >= 3), so a read
  // never meets a pending write to the same entry, except across a frame restart.
  // ---------------------------------------------------------------------------
  line_entry_t ram_q;
  line_entry_t ram_wdata;
  logic [$bits(line_entry_t)-1:0] ram_rdata;

  assign ram_q = line_entry_t'(ram_rdata);
  assign ram_wdata = '{gy: a_gy, gx: a_gx, prev: a_mag, prev2: ram_q.prev};

  gnms_line_ram #(
    .DATA_W ($bits(line_entry_t)),
    .ADDR_W (COL_W)
  ) u_line_ram (
    .clk   (clk),
    .we    (a_go),
    .waddr (a_col),
    .wdata (ram_wdata),
    .re    (in_acc),
    .raddr (col_cnt),
    .rdata (ram_rdata)
  );

  // ---------------------------------------------------------------------------
  // Stage B: window shift and octant weights.
  // ---------------------------------------------------------------------------
  oct_t    oct;
  logic    centre_zero;
  logic    b_valid, b_free;
  dec_in_t b_data;
  logic    dec_ready;

  gnms_window u_window (
    .clk         (clk),
    .rst         (rst),
    .shift_en    (a_go),
    .col_top     (ram_q.prev2),
    .col_mid     (ram_q.prev),
    .col_bot     (a_mag),
    .new_grad    ({ram_q.gy, ram_q.gx}),
    .oct         (oct),
    .centre_zero (centre_zero)
  );

  assign b_free        = !b_valid || dec_ready;
  assign a_free        = !a_valid || b_free;
  assign a_go          = a_valid && b_free;
  assign s_axis_tready = a_free;

  // pixels in row 0 or column 0 shift the window but give no result
  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (b_free) begin
      b_valid <= a_valid && a_emit;
    end
  end

  always_ff @(posedge clk) begin
    if (a_go) begin
      b_data <= '{oct: oct, zero: centre_zero, border: a_border,
                  row: a_crow, col: a_ccol, last: a_last};
    end
  end

  // ---------------------------------------------------------------------------
  // Stages C and output: projections, decision, output register.
  // ---------------------------------------------------------------------------
  logic [1:0] o_code;
  row_t       o_row;
  col_t       o_col;

  gnms_decide u_decide (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (b_valid),
    .in_ready  (dec_ready),
    .in_data   (b_data),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .code      (o_code),
    .row       (o_row),
    .col       (o_col),
    .last      (m_axis_tlast)
  );

  assign m_axis_tdata = {2'b00, o_col, o_row, o_code};

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `GNMS_ASSERT_NOW(a_col_in_range, 1'b1, {1'b0, col_cnt} < eff_w, "column beyond width")
  `GNMS_ASSERT_NEXT(a_cfg_restart, cfg_we, row_cnt == '0 && col_cnt == '0, "no frame restart")
  `GNMS_ASSERT_NOW(a_edge_border, m_axis_tvalid && (o_row == '0 || o_col == '0),
                   o_code == CODE_BORDER, "edge pixel not border")
  `GNMS_ASSERT_NOW(a_code_legal, m_axis_tvalid,
                   o_code == CODE_BORDER || o_code == CODE_NOT_MAX ||
                   o_code == CODE_CANDIDATE, "illegal result code")

endmodule

FILE: test/gradient_non_max_suppression_core_tb.sv
// Self-checking testbench for gradient_non_max_suppression_core.
// Predicts every result from the pixel stream and compares it with m_axis.
// Depends on gnms_pkg and the DUT sources only.
`timescale 1ns / 100ps

module gradient_non_max_suppression_core_tb;
  import gnms_pkg::*;

  localparam int QUIET_LIMIT    = 4000;  // cycles with no transaction before giving up
  localparam int DRAIN_CYCLES   = 10;    // pixels with no result may still be in flight
  localparam int RANDOM_PIXELS  = 1050;
  localparam int MAX_REPORTS    = 50;

  // expected content of one m_axis transaction
  typedef struct packed {
    logic [1:0] code;
    row_t       row;
    col_t       col;
    logic       last;
  } nms_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic        cfg_index = CFG_IMAGE_WIDTH;
  logic [15:0] cfg_data = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata = '0;   // grad_magnitude[14:0], grad_x[30:15], grad_y[46:31]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;        // nms_code[1:0], centre_row[17:2], centre_col[29:18]
  logic        m_axis_tlast;        // frame_done

  gradient_non_max_suppression_core u_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Predictor state: line stores, 3x3 magnitude window, centre gradient pipe,
  // raster counters and the two size registers, all as the block keeps them.
  // ---------------------------------------------------------------------------
  logic [WIDTH_W-1:0]  width_reg;
  logic [HEIGHT_W-1:0] height_reg;
  mag_t        mag_above   [MAX_WIDTH];
  mag_t        mag_above2  [MAX_WIDTH];
  gval_t       gx_above    [MAX_WIDTH];
  gval_t       gy_above    [MAX_WIDTH];
  longint      win_mag     [3][3];
  gval_t       centre_gx   [2];
  gval_t       centre_gy   [2];
  int unsigned row_cnt;
  int unsigned col_cnt;

  nms_result_t pending_results[$];
  int          mismatches = 0;
  int          quiet_cycles = 0;

  // sender and receiver pacing knobs, set per test
  int gap_max     = 0;
  int burst_left  = 0;
  int stall_pct   = 0;
  int hold_len    = 0;
  bit hold_req    = 1'b0;

  task automatic reset_model;
    width_reg  = RESET_WIDTH;
    height_reg = RESET_HEIGHT;
    for (int i = 0; i < MAX_WIDTH; i++) begin
      mag_above[i]  = '0;
      mag_above2[i] = '0;
      gx_above[i]   = '0;
      gy_above[i]   = '0;
    end
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++)
        win_mag[i][j] = 0;
    centre_gx = '{default: '0};
    centre_gy = '{default: '0};
    row_cnt = 0;
    col_cnt = 0;
  endtask

  // any register write restarts the frame
  task automatic apply_config(input logic idx, input logic [15:0] val);
    if (idx == CFG_IMAGE_WIDTH) width_reg = val[WIDTH_W-1:0];
    else height_reg = val;
    row_cnt = 0;
    col_cnt = 0;
  endtask

  // gradient projection numerator, already scaled by the positive magnitude
  function automatic longint proj(longint a, longint b, longint gx, longint gy);
    return b * gy - a * gx;
  endfunction

  // Octant selection and interpolation on the current window.
  // Ties go to the x-dominant case except when both gradients are negative.
  function automatic logic [1:0] classify_centre(gval_t gx_v, gval_t gy_v);
    longint gx, gy, m, z1, z2, y1, y2, p1, p2;
    gx = longint'(gx_v);
    gy = longint'(gy_v);
    m  = win_mag[1][1];
    if (m == 0) return CODE_NOT_MAX;   // flat centre is never an edge
    if (gx >= 0) begin
      if (gy >= 0) begin
        if (gx >= gy) begin
          z1 = win_mag[1][0]; z2 = win_mag[0][0]; y1 = win_mag[1][2]; y2 = win_mag[2][2];
          p1 = proj(m - z1, z2 - z1, gx, gy);
          p2 = proj(m - y1, y2 - y1, gx, gy);
        end else begin
          z1 = win_mag[0][1]; z2 = win_mag[0][0]; y1 = win_mag[2][1]; y2 = win_mag[2][2];
          p1 = proj(z1 - z2, z1 - m, gx, gy);
          p2 = proj(y1 - y2, y1 - m, gx, gy);
        end
      end else begin
        if (gx >= -gy) begin
          z1 = win_mag[1][0]; z2 = win_mag[2][0]; y1 = win_mag[1][2]; y2 = win_mag[0][2];
          p1 = proj(m - z1, z1 - z2, gx, gy);
          p2 = proj(m - y1, y1 - y2, gx, gy);
        end else begin
          z1 = win_mag[2][1]; z2 = win_mag[2][0]; y1 = win_mag[0][1]; y2 = win_mag[0][2];
          p1 = proj(z1 - z2, m - z1, gx, gy);
          p2 = proj(y1 - y2, m - y1, gx, gy);
        end
      end
    end else begin
      if (gy >= 0) begin
        if (-gx >= gy) begin
          z1 = win_mag[1][2]; z2 = win_mag[0][2]; y1 = win_mag[1][0]; y2 = win_mag[2][0];
          p1 = proj(z1 - m, z2 - z1, gx, gy);
          p2 = proj(y1 - m, y2 - y1, gx, gy);
        end else begin
          z1 = win_mag[0][1]; z2 = win_mag[0][2]; y1 = win_mag[2][1]; y2 = win_mag[2][0];
          p1 = proj(z2 - z1, z1 - m, gx, gy);
          p2 = proj(y2 - y1, y1 - m, gx, gy);
        end
      end else begin
        // third quadrant: strict compare, ties take the y-dominant case
        if (-gx > -gy) begin
          z1 = win_mag[1][2]; z2 = win_mag[2][2]; y1 = win_mag[1][0]; y2 = win_mag[0][0];
          p1 = proj(z1 - m, z1 - z2, gx, gy);
          p2 = proj(y1 - m, y1 - y2, gx, gy);
        end else begin
          z1 = win_mag[2][1]; z2 = win_mag[2][2]; y1 = win_mag[0][1]; y2 = win_mag[0][0];
          p1 = proj(z2 - z1, m - z1, gx, gy);
          p2 = proj(y2 - y1, m - y1, gx, gy);
        end
      end
    end
    return (p1 > 0 || p2 >= 0) ? CODE_NOT_MAX : CODE_CANDIDATE;
  endfunction

  // Advance the predictor by one accepted pixel; queue the result it causes.
  // Pixel (r,c) completes the window of (r-1,c-1).
  task automatic predict_pixel(input mag_t mag, input gval_t gx, input gval_t gy);
    int unsigned wdt, hgt, r, c;
    nms_result_t res;
    wdt = (width_reg < MIN_DIM) ? MIN_DIM : (width_reg > MAX_WIDTH) ? MAX_WIDTH : width_reg;
    hgt = (height_reg < MIN_DIM) ? MIN_DIM : height_reg;
    r = row_cnt;
    c = col_cnt;
    for (int i = 0; i < 3; i++) begin
      win_mag[i][0] = win_mag[i][1];
      win_mag[i][1] = win_mag[i][2];
    end
    win_mag[0][2] = longint'(mag_above2[c]);
    win_mag[1][2] = longint'(mag_above[c]);
    win_mag[2][2] = longint'(mag);
    centre_gx[1] = centre_gx[0];
    centre_gy[1] = centre_gy[0];
    centre_gx[0] = gx_above[c];
    centre_gy[0] = gy_above[c];
    mag_above2[c] = mag_above[c];
    mag_above[c]  = mag;
    gx_above[c]   = gx;
    gy_above[c]   = gy;

    if (r >= 1 && c >= 1) begin
      res.row  = row_t'(r - 1);
      res.col  = col_t'(c - 1);
      res.code = (r == 1 || c == 1) ? CODE_BORDER : classify_centre(centre_gx[1], centre_gy[1]);
      res.last = (r + 1 >= hgt && c + 1 >= wdt);
      pending_results.push_back(res);
    end

    if (c + 1 >= wdt) begin
      col_cnt = 0;
      row_cnt = (r + 1 >= hgt) ? 0 : r + 1;
    end else begin
      col_cnt = c + 1;
    end
  endtask

  task automatic check_result;
    nms_result_t got, want;
    got.code = m_axis_tdata[1:0];
    got.row  = m_axis_tdata[17:2];
    got.col  = m_axis_tdata[29:18];
    got.last = m_axis_tlast;
    if (pending_results.size() == 0) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("%0t: unexpected result code %0d row %0d col %0d last %0b",
                 $realtime, got.code, got.row, got.col, got.last);
    end else begin
      want = pending_results.pop_front();
      if (got.code !== want.code || got.row !== want.row ||
          got.col !== want.col || got.last !== want.last) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: mismatch expected code %0d row %0d col %0d last %0b, actual code %0d row %0d col %0d last %0b",
                   $realtime, want.code, want.row, want.col, want.last,
                   got.code, got.row, got.col, got.last);
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Monitor: one process handles register writes, input and output
  // transactions in that order, so a result is never checked before the pixel
  // that caused it has been predicted. It also runs the watchdog.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_we) apply_config(cfg_index, cfg_data);
      if (s_axis_tvalid && s_axis_tready)
        predict_pixel(s_axis_tdata[14:0], s_axis_tdata[30:15], s_axis_tdata[46:31]);
      if (m_axis_tvalid && m_axis_tready) check_result();

      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we)
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("%0t: watchdog, no transaction for %0d cycles", $realtime, QUIET_LIMIT);
        $display("Some tests failed");
        $finish;
      end
    end
  end

  // Receiver: ready and stall in random runs; a hold-off request from a test
  // turns into a long stall counted here.
  int  hold_left = 0;
  int  run_left  = 0;
  bit  run_ready = 1'b1;
  always @(negedge clk) begin
    if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = hold_len;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      if (run_left == 0) begin
        run_ready = ($urandom_range(0, 99) >= stall_pct);
        run_left  = $urandom_range(1, 8);
      end
      run_left--;
      m_axis_tready <= run_ready;
    end
  end

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------

  // One pixel transaction. Bursts of random length, random gaps between them.
  // tvalid stays high on return; the next call or wait_idle drives it next.
  task automatic send_pixel(input mag_t mag, input gval_t gx, input gval_t gy);
    int gap;
    @(negedge clk);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 32);
      gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {1'b0, gy, gx, mag};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
  endtask

  // Stop offering pixels, let every expected result drain, then allow for
  // pixels still inside the pipeline that produce nothing.
  task automatic wait_idle;
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [15:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic set_size(input logic [15:0] w, input logic [15:0] h);
    wait_idle();
    write_reg(CFG_IMAGE_WIDTH, w);
    write_reg(CFG_IMAGE_HEIGHT, h);
  endtask

  // Pixel content. mode 0: fully random; 1: tiny values so ties and equal
  // neighbors are common; 2: random with zero magnitudes and extreme gradients.
  task automatic make_pixel(input int mode, output mag_t mag, output gval_t gx,
                            output gval_t gy);
    gval_t extremes[5];
    extremes = '{16'sh8000, 16'sh7fff, 16'sh0000, -16'sd1, 16'sd1};
    case (mode)
      0: begin
        mag = mag_t'($urandom_range(0, 32767));
        gx  = gval_t'($urandom);
        gy  = gval_t'($urandom);
      end
      1: begin
        mag = mag_t'($urandom_range(0, 7));
        gx  = gval_t'($signed($urandom_range(0, 6)) - 3);
        gy  = gval_t'($signed($urandom_range(0, 6)) - 3);
      end
      default: begin
        mag = ($urandom_range(0, 9) == 0) ? '0 : mag_t'($urandom_range(0, 32767));
        gx  = ($urandom_range(0, 9) == 0) ? extremes[$urandom_range(0, 4)] : gval_t'($urandom);
        gy  = ($urandom_range(0, 9) == 0) ? extremes[$urandom_range(0, 4)] : gval_t'($urandom);
      end
    endcase
  endtask

  task automatic send_random_pixels(input int count, input int mode);
    mag_t  mag;
    gval_t gx, gy;
    repeat (count) begin
      make_pixel(mode, mag, gx, gy);
      send_pixel(mag, gx, gy);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // 8x3 frame: the middle row covers first-octant, x/y ties in several
  // quadrants (strict one in the third), zero magnitude and extreme gradients;
  // outer rows carry extreme magnitudes. Ends with frame_done.
  task automatic test_directed_cases;
    int dmag[24] = '{   10,    20,    30,    40,    50,    60,    70, 32767,
                         0,    90,    80,    80,    70,     0,    95,     5,
                        15,    25,    35,    45,    55,    65,    75,     0};
    int dgx[24]  = '{-32768, 32767,     0,     1,    -1,     0,     0,     0,
                          0,     3,     5,     7,    -4,     2,-32768,    -9,
                      32767,-32768,    -6,     6,     0,     1,    -1,     0};
    int dgy[24]  = '{ 32767,-32768,     0,    -1,     1,     0,     0,     0,
                          0,     1,     5,    -7,    -4,    -2, 32767,     9,
                     -32768, 32767,     6,    -6,     0,    -1,     1,     0};
    gap_max   = 3;
    stall_pct = 30;
    set_size(8, 3);
    for (int i = 0; i < 24; i++)
      send_pixel(mag_t'(dmag[i]), gval_t'(dgx[i]), gval_t'(dgy[i]));
  endtask

  // Register extremes: sizes below the minimum, a width above the line store,
  // the largest height.
  task automatic test_register_limits;
    gap_max   = 2;
    stall_pct = 20;
    set_size(0, 0);                        // both act as 3
    send_random_pixels(18, 2);             // two back-to-back frames
    wait_idle();
    write_reg(CFG_IMAGE_WIDTH, 16'h1fff);  // acts as MAX_WIDTH
    send_random_pixels(40, 0);             // part of row 0, no wrap yet
    set_size(3, 16'hffff);
    send_random_pixels(15, 2);
    wait_idle();
    write_reg(CFG_IMAGE_WIDTH, 2);         // acts as 3
    send_random_pixels(9, 1);
  endtask

  // A register write in the middle of a frame restarts it from row 0.
  task automatic test_frame_restart;
    gap_max   = 4;
    stall_pct = 40;
    set_size(6, 5);
    send_random_pixels(15, 0);
    wait_idle();
    write_reg(CFG_IMAGE_HEIGHT, 5);
    send_random_pixels(30, 2);
    wait_idle();
    write_reg(CFG_IMAGE_WIDTH, 6);
    send_random_pixels(30, 1);
  endtask

  // Whole frames of random size and content, sometimes two in a row
  // without reconfiguration; pacing changes per frame, including full rate.
  task automatic test_random_frames;
    int sent, w, h, mode, frames;
    sent = 0;
    while (sent < RANDOM_PIXELS) begin
      w = ($urandom_range(0, 9) < 8) ? $urandom_range(3, 12) : $urandom_range(13, 40);
      h = $urandom_range(3, 8);
      frames = ($urandom_range(0, 4) == 0) ? 2 : 1;
      mode = $urandom_range(0, 2);
      if ($urandom_range(0, 3) == 0) begin
        gap_max   = 0;
        stall_pct = 0;
      end else begin
        gap_max   = $urandom_range(1, 6);
        stall_pct = $urandom_range(10, 70);
      end
      set_size(16'(w), 16'(h));
      send_random_pixels(w * h * frames, mode);
      sent += w * h * frames;
    end
  endtask

  // Receiver holds off for a long stretch while the sender keeps pushing at
  // full rate: the pipeline fills and s_axis_tready must drop.
  task automatic test_output_backpressure;
    gap_max   = 0;
    stall_pct = 0;
    set_size(9, 10);
    hold_len = 300;
    hold_req = 1'b1;
    send_random_pixels(90, 0);
  endtask

  initial begin
    reset_model();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed_cases();
    test_register_limits();
    test_frame_restart();
    test_random_frames();
    test_output_backpressure();

    wait_idle();
    repeat (20) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+sv
sv/gnms_pkg.sv
sv/gnms_line_ram.sv
sv/gnms_window.sv
sv/gnms_decide.sv
sv/gradient_non_max_suppression_core.sv
test/gradient_non_max_suppression_core_tb.sv
